@@ hdl/crlu_pkg.sv @@
`timescale 1ns / 1ps
// crlu_pkg: shared types, request and status codes for the crout lu block
// no dependencies

package crlu_pkg;

	localparam int MAX_ORDER_DEF = 64;
	localparam int DIV_STEPS     = 32;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_DECOMP = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_SINGULAR  = 2'd1;
	localparam logic [1:0] ST_SATURATED = 2'd2;

	localparam logic [6:0] SIZE_RESET = 7'd64;

	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] lower_value;
		logic signed [31:0] upper_value;
		logic [1:0]         status;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic               sat;
		logic signed [31:0] quo;
	} div_res_t;

endpackage

@@ hdl/crlu_stream_if.sv @@
`timescale 1ns / 1ps
// crlu_stream_if: valid/ready channel carrying one payload per transaction
// payload type is a parameter, no other dependencies

interface crlu_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/crlu_divider.sv @@
`timescale 1ns / 1ps
// crlu_divider: radix-2 restoring divider for num * 2^16 / piv, saturating
// depends on crlu_pkg

module crlu_divider import crlu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] piv,
	output div_res_t           res
);

	logic [63:0] un;
	logic [31:0] ud;
	logic        neg;
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] quo_q;
	logic [31:0] ud_q;
	logic        neg_q;
	div_res_t    res_q;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign neg   = num[63] ^ piv[31];
	assign un    = num[63] ? 64'(-num) : 64'(num);
	assign ud    = piv[31] ? 32'(-piv) : 32'(piv);
	assign trial = {rem_q, low_q[31]};
	assign ge    = trial >= {1'b0, ud_q};
	assign diff  = trial - {1'b0, ud_q};
	assign res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			res_q  <= '0;
		end else begin
			res_q.valid <= 1'b0;
			if (start) begin
				neg_q <= neg;
				ud_q  <= ud;
				if (un >= {16'h0, ud, 16'h0}) begin
					res_q.valid <= 1'b1;
					res_q.sat   <= 1'b1;
					res_q.quo   <= neg ? Q_MIN : Q_MAX;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					rem_q  <= un[47:16];
					low_q  <= {un[15:0], 16'h0};
					quo_q  <= '0;
				end
			end else if (busy_q) begin
				if (cnt_q == 6'(DIV_STEPS)) begin
					busy_q      <= 1'b0;
					res_q.valid <= 1'b1;
					if (neg_q) begin
						res_q.sat <= quo_q > 32'h8000_0000;
						res_q.quo <= (quo_q > 32'h8000_0000) ? Q_MIN : 32'(-quo_q);
					end else begin
						res_q.sat <= quo_q[31];
						res_q.quo <= quo_q[31] ? Q_MAX : quo_q;
					end
				end else begin
					rem_q <= ge ? diff[31:0] : trial[31:0];
					low_q <= {low_q[30:0], 1'b0};
					quo_q <= {quo_q[30:0], ge};
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

endmodule

@@ hdl/crout_lu_decomposition.sv @@
`timescale 1ns / 1ps
// crout_lu_decomposition: q16.16 crout lu factorization over on-chip matrix memories
// depends on crlu_pkg, crlu_stream_if, crlu_divider
//
// Requests arrive on req, results leave on rsp; both are valid/ready channels.
// A load writes one element of A and gives no result; one load per cycle while idle.
// A read returns L and U at one position plus the last status through the memory
// read and output registers; reads also run one per cycle while rsp drains.
// A decompose returns one status result when done; req is held off meanwhile.
// It runs on the single multiply-accumulate datapath fed by the L and U memory read
// ports; each U entry right of the diagonal goes through the bit-serial divider.
// size_in_use is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Reset clears control state, sets size_in_use to 64 and the status to ok;
// matrix contents are undefined until loaded or computed.
// A stalled rsp holds its result; a pending read then holds off req.

module crout_lu_decomposition import crlu_pkg::*; #(
	parameter int MAX_ORDER = MAX_ORDER_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	crlu_stream_if.sink   req,
	crlu_stream_if.source rsp
);

	localparam int IW = $clog2(MAX_ORDER);
	localparam int CW = $clog2(MAX_ORDER + 1);
	localparam int AW = $clog2(MAX_ORDER * MAX_ORDER);
	localparam int DEPTH = MAX_ORDER * MAX_ORDER;

	typedef enum logic [2:0] {
		S_IDLE, S_START, S_ELEM, S_MAC, S_FIN, S_DIV, S_NEXT, S_DONE
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
		addr_of = AW'(r) * AW'(MAX_ORDER) + AW'(c);
	endfunction

	logic signed [31:0] a_mem [DEPTH];
	logic signed [31:0] l_mem [DEPTH];
	logic signed [31:0] u_mem [DEPTH];

	state_t             state_q;
	logic [6:0]         size_q;
	logic [1:0]         status_q;
	logic [CW-1:0]      n_q;
	logic [CW-1:0]      i_q;
	logic [CW-1:0]      j_q;
	logic [CW-1:0]      k_q;
	logic               phase_q;
	logic               sat_q;
	logic signed [31:0] piv_q;
	logic signed [63:0] acc_q;
	logic               a_s1;
	logic               v_s1;
	logic               v_s2;
	logic signed [63:0] prod_s2;
	logic               rd_s1;
	logic               in_range_s1;
	logic               out_valid_q;
	rsp_t               out_q;
	logic signed [31:0] a_rdata_q;
	logic signed [31:0] l_rdata_q;
	logic signed [31:0] u_rdata_q;

	logic               accept;
	logic               in_range;
	logic               out_free;
	logic               stall;
	logic [IW-1:0]      r_idx;
	logic [IW-1:0]      c_idx;
	logic [IW-1:0]      k_idx;
	logic [AW-1:0]      user_addr;
	logic               a_we;
	logic               a_re;
	logic [AW-1:0]      a_raddr;
	logic               l_we;
	logic [AW-1:0]      l_waddr;
	logic signed [31:0] l_wdata;
	logic               u_we;
	logic [AW-1:0]      u_waddr;
	logic signed [31:0] u_wdata;
	logic               lu_re;
	logic [AW-1:0]      l_raddr;
	logic [AW-1:0]      u_raddr;
	logic               issue;
	logic signed [63:0] rnd;
	logic signed [31:0] acc_sat;
	logic               acc_ovf;
	logic               div_start;
	div_res_t           div_res;

	assign out_free  = !out_valid_q || rsp.ready;
	assign stall     = rd_s1 && !out_free;
	assign req.ready = (state_q == S_IDLE) && !stall;
	assign accept    = req.valid && req.ready;
	assign in_range  = (32'(req.data.row) < 32'(MAX_ORDER)) && (32'(req.data.col) < 32'(MAX_ORDER));
	assign user_addr = addr_of(IW'(req.data.row), IW'(req.data.col));

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	assign r_idx = IW'(phase_q ? i_q : j_q);
	assign c_idx = IW'(phase_q ? j_q : i_q);
	assign k_idx = IW'(k_q);
	assign issue = (state_q == S_MAC) && (k_q < i_q);
	assign rnd   = (prod_s2 + 64'sd32768) >>> 16;

	always_comb begin
		acc_ovf = 1'b1;
		if (acc_q > 64'sh0000_0000_7fff_ffff) begin
			acc_sat = Q_MAX;
		end else if (acc_q < -64'sh0000_0000_8000_0000) begin
			acc_sat = Q_MIN;
		end else begin
			acc_sat = acc_q[31:0];
			acc_ovf = 1'b0;
		end
	end

	always_comb begin
		a_we      = accept && (req.data.req_type == REQ_LOAD) && in_range;
		a_re      = (state_q == S_ELEM) && !(phase_q ? (j_q <= i_q) : (j_q < i_q));
		a_raddr   = addr_of(r_idx, c_idx);
		l_we      = 1'b0;
		l_waddr   = addr_of(r_idx, c_idx);
		l_wdata   = acc_sat;
		u_we      = 1'b0;
		u_waddr   = addr_of(r_idx, c_idx);
		u_wdata   = div_res.quo;
		lu_re     = issue;
		l_raddr   = addr_of(r_idx, k_idx);
		u_raddr   = addr_of(k_idx, c_idx);
		div_start = (state_q == S_FIN) && phase_q;
		if (state_q == S_IDLE) begin
			lu_re   = accept && (req.data.req_type == REQ_READ) && in_range;
			l_raddr = user_addr;
			u_raddr = user_addr;
		end
		if (state_q == S_ELEM && !a_re) begin
			if (phase_q) begin
				u_we    = 1'b1;
				u_wdata = (j_q == i_q) ? Q_ONE : '0;
			end else begin
				l_we    = 1'b1;
				l_wdata = '0;
			end
		end
		if (state_q == S_FIN && !phase_q) begin
			l_we = 1'b1;
		end
		if (state_q == S_DIV && div_res.valid) begin
			u_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[user_addr] <= req.data.value;
		end
		if (a_re) begin
			a_rdata_q <= a_mem[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			l_mem[l_waddr] <= l_wdata;
		end
		if (lu_re) begin
			l_rdata_q <= l_mem[l_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (u_we) begin
			u_mem[u_waddr] <= u_wdata;
		end
		if (lu_re) begin
			u_rdata_q <= u_mem[u_raddr];
		end
	end

	crlu_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.piv    (piv_q),
		.res    (div_res)
	);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= l_rdata_q * u_rdata_q;
		end
		if (a_s1) begin
			acc_q <= 64'(a_rdata_q);
		end else if (v_s2) begin
			acc_q <= acc_q - rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			size_q      <= SIZE_RESET;
			status_q    <= ST_OK;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			sat_q       <= 1'b0;
			a_s1        <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rd_s1       <= 1'b0;
			in_range_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			piv_q       <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			a_s1 <= a_re;
			v_s1 <= issue;
			v_s2 <= v_s1;

			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_s1 && out_free) begin
				rd_s1             <= 1'b0;
				out_valid_q       <= 1'b1;
				out_q.lower_value <= in_range_s1 ? l_rdata_q : '0;
				out_q.upper_value <= in_range_s1 ? u_rdata_q : '0;
				out_q.status      <= status_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && req.data.req_type == REQ_READ) begin
						rd_s1       <= 1'b1;
						in_range_s1 <= in_range;
					end
					if (accept && req.data.req_type == REQ_DECOMP) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (!rd_s1) begin
						if (size_q == 7'd0) begin
							n_q <= CW'(1);
						end else if (32'(size_q) > 32'(MAX_ORDER)) begin
							n_q <= CW'(MAX_ORDER);
						end else begin
							n_q <= CW'(size_q);
						end
						i_q     <= '0;
						j_q     <= '0;
						phase_q <= 1'b0;
						sat_q   <= 1'b0;
						state_q <= S_ELEM;
					end
				end
				S_ELEM: begin
					k_q     <= '0;
					state_q <= a_re ? S_MAC : S_NEXT;
				end
				S_MAC: begin
					if (issue) begin
						k_q <= k_q + CW'(1);
					end else if (!a_s1 && !v_s1 && !v_s2) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (phase_q) begin
						state_q <= S_DIV;
					end else begin
						if (acc_ovf) begin
							sat_q <= 1'b1;
						end
						if (j_q == i_q) begin
							piv_q <= acc_sat;
						end
						state_q <= S_NEXT;
					end
				end
				S_DIV: begin
					if (div_res.valid) begin
						if (div_res.sat) begin
							sat_q <= 1'b1;
						end
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (j_q + CW'(1) == n_q) begin
						j_q <= '0;
						if (!phase_q) begin
							if (piv_q == '0) begin
								status_q <= ST_SINGULAR;
								state_q  <= S_DONE;
							end else begin
								phase_q <= 1'b1;
								state_q <= S_ELEM;
							end
						end else begin
							phase_q <= 1'b0;
							i_q     <= i_q + CW'(1);
							if (i_q + CW'(1) == n_q) begin
								status_q <= sat_q ? ST_SATURATED : ST_OK;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_ELEM;
							end
						end
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= S_ELEM;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.lower_value <= '0;
						out_q.upper_value <= '0;
						out_q.status      <= status_q;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> state_q == S_IDLE)
		else $error("request accepted while decomposition active");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_s1 && out_valid_q && !rsp.ready) |=> rd_s1)
		else $error("pending read dropped while response stalled");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.valid |-> state_q == S_DIV)
		else $error("divider result outside divide state");

	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> k_q <= i_q)
		else $error("mac index past step");

endmodule
